>>> src/sorted_timeout_timer_table_core_macros.svh
// Assertion macros for the sorted timer table core.
// Used by the top level; no other dependencies.
`ifndef SORTED_TIMEOUT_TIMER_TABLE_CORE_MACROS_SVH
`define SORTED_TIMEOUT_TIMER_TABLE_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define STT_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define STT_ASSERT_NORST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define STT_ASSERT(label, clk, rst, prop, msg)
`define STT_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

>>> src/stt_pkg.sv
// Package for the sorted timer table: types, codes and constants.
// No dependencies.
`default_nettype none
package stt_pkg;
   localparam int NUM_TIMERS_DEF = 16;
   localparam logic [31:0] DL_MAX = 32'hffff_ffff;

   typedef enum logic [2:0] {
      FN_TICK = 3'd0, FN_ALLOC = 3'd1, FN_FREE = 3'd2, FN_INIT = 3'd3, FN_SET = 3'd4
   } func_type;

   typedef enum logic [1:0] {
      FL_FREE = 2'd0, FL_ALLOC = 2'd1, FL_RUN = 2'd2
   } flag_type;

   typedef enum logic [1:0] {
      ST_OK = 2'd0, ST_NOFREE = 2'd1, ST_BAD = 2'd2
   } status_type;

   typedef struct packed {
      logic [2:0]  func;
      logic [3:0]  timer_index;
      logic [31:0] delay;
      logic [7:0]  data_byte;
      logic [1:0]  queue_id;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [3:0] entry;
      logic [7:0] expiry_byte;
      logic [1:0] dest_queue;
      logic       sched_switch;
      logic       is_expiry;
      logic       last;
   } rsp_type;
endpackage
`default_nettype wire

>>> src/stt_if.sv
// Valid/ready channel interfaces for requests, responses and csr writes.
// Depends on stt_pkg.
`default_nettype none
interface stt_req_if;
   logic              valid;
   logic              ready;
   stt_pkg::req_type  payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface stt_rsp_if;
   logic              valid;
   logic              ready;
   stt_pkg::rsp_type  payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface stt_csr_if;
   logic        valid;
   logic        ready;
   logic [4:0]  data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> src/sorted_timeout_timer_table_core.sv
// Sorted timer table: a chain of slot cells keeps running entries in deadline
// order, slot 0 at the head; an insert shifts the chain in the accepting cycle.
// A non-tick request replies in the cycle after acceptance; no new request is taken
// until that reply is taken. A tick with k expired entries (k at most LIM-1) emits
// one expiry per cycle from the head while the response is taken, and stalls otherwise.
// Reset is synchronous, active high, and leaves only the sentinel running.
`default_nettype none
`include "sorted_timeout_timer_table_core_macros.svh"
module sorted_timeout_timer_table_core #(
   parameter int NUM_TIMERS = stt_pkg::NUM_TIMERS_DEF
) (
   input wire logic  clock,
   input wire logic  reset,
   stt_req_if.sink   req,
   stt_rsp_if.source rsp,
   stt_csr_if.sink   csr
);
   localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int NS = NUM_TIMERS;        // chain slots, sentinel included
   localparam int LIM = (NUM_TIMERS < 16) ? NUM_TIMERS : 16;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001, S_WALK = 3'b010, S_OUT = 3'b100
   } state_type;

   state_type      state_ff, state_in;
   logic [4:0]     ttask_ff;
   logic [31:0]    count_ff;
   logic [1:0]     flag_ff [NS];
   logic [7:0]     byte_mem [NS];
   logic [1:0]     queue_mem [NS];
   logic [3:0]     nexp_ff;
   stt_pkg::rsp_type out_ff;
   logic           out_v_ff, out_v_in;
   stt_pkg::req_type rq;
   stt_pkg::rsp_type reply_in;

   logic [IW-1:0]  c_idx [NS];
   logic [31:0]    c_dl [NS];
   logic [NS-1:0]  ge;            // new deadline <= slot deadline, or slot empty
   logic [NS-1:0]  here;
   logic           shift_en, ins_en;
   logic [IW-1:0]  ins_idx;
   logic [31:0]    ins_dl;
   logic           emit_sw, emit_last;

   assign rq = req.payload;
   assign csr.ready = 1'b1;
   assign req.ready = (state_ff == S_IDLE) && !out_v_ff;
   assign rsp.valid = out_v_ff;
   assign rsp.payload = out_ff;

   // insertion point: first slot that is empty or whose deadline is not below the new one
   assign ins_dl  = rq.delay + count_ff;
   assign ins_idx = IW'(rq.timer_index);
   always_comb begin
      for (int k = 0; k < NS; k++) begin
         ge[k] = (ins_dl <= c_dl[k]) || (c_idx[k] == '0);
      end
      here[0] = ge[0];
      for (int k = 1; k < NS; k++) begin
         here[k] = ge[k] && !ge[k-1];
      end
   end

   // expired head at slot 0
   logic head_exp;
   assign head_exp = (c_idx[0] != '0) && (c_dl[0] <= count_ff) && (nexp_ff < 4'(LIM - 1));

   logic req_acc, valid_idx, op_set;
   assign req_acc   = req.valid && req.ready;
   assign valid_idx = 32'(rq.timer_index) < 32'(NUM_TIMERS);
   assign op_set    = req_acc && rq.func == stt_pkg::FN_SET && valid_idx &&
                      flag_ff[ins_idx] != stt_pkg::FL_RUN;
   assign ins_en    = op_set;
   assign shift_en  = (state_ff == S_WALK) && head_exp && (!out_v_ff || rsp.ready);

   // chain of slots: slot 0 is the head
   for (genvar g = 0; g < NS; g++) begin : g_cell
      stt_cell #(.IW(IW)) u_cell (
         .clock(clock), .reset(reset), .shift_en(shift_en),
         .up_idx((g == NS-1) ? c_idx[g] : c_idx[(g == NS-1) ? g : g+1]),
         .up_dl((g == NS-1) ? c_dl[g] : c_dl[(g == NS-1) ? g : g+1]),
         .up_ins(ge[g] && !here[g]), .ins_en(ins_en), .ins_here(here[g]),
         .ins_idx(ins_idx), .ins_dl(ins_dl),
         .dn_idx(c_idx[(g == 0) ? 0 : g-1]), .dn_dl(c_dl[(g == 0) ? 0 : g-1]),
         .idx_q(c_idx[g]), .dl_q(c_dl[g])
      );
   end

   // alloc search over the flag row
   logic [IW-1:0] free_idx;
   logic          free_ok;
   always_comb begin
      free_idx = '0;
      free_ok  = 1'b0;
      for (int k = LIM - 1; k >= 1; k--) begin
         if (flag_ff[k] == stt_pkg::FL_FREE) begin
            free_idx = IW'(k);
            free_ok  = 1'b1;
         end
      end
   end

   // reply for a non-tick request
   always_comb begin
      reply_in = '0;
      reply_in.last = 1'b1;
      reply_in.entry = rq.timer_index;
      case (rq.func)
         stt_pkg::FN_TICK: begin
         end
         stt_pkg::FN_ALLOC: begin
            reply_in.entry = free_ok ? 4'(free_idx) : 4'd0;
            reply_in.status = free_ok ? stt_pkg::ST_OK : stt_pkg::ST_NOFREE;
         end
         stt_pkg::FN_INIT: begin
            if (!valid_idx) reply_in.status = stt_pkg::ST_BAD;
         end
         stt_pkg::FN_FREE, stt_pkg::FN_SET: begin
            if (!valid_idx || flag_ff[ins_idx] == stt_pkg::FL_RUN)
               reply_in.status = stt_pkg::ST_BAD;
         end
         default: begin
            reply_in.status = stt_pkg::ST_BAD;
            reply_in.entry = 4'd0;
         end
      endcase
   end

   // head expiry fields, looking one slot ahead for the last flag
   assign emit_sw   = (5'(c_idx[0]) == ttask_ff);
   assign emit_last = !((c_idx[(NS > 1) ? 1 : 0] != '0) &&
                        (c_dl[(NS > 1) ? 1 : 0] <= count_ff) &&
                        (nexp_ff + 4'd1 < 4'(LIM - 1)));

   // output register: load on a reply or an expiry, clear once taken
   always_comb begin
      out_v_in = out_v_ff && !rsp.ready;
      if ((req_acc && rq.func != stt_pkg::FN_TICK) || shift_en) out_v_in = 1'b1;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (req_acc && rq.func == stt_pkg::FN_TICK) state_in = S_WALK;
         S_WALK: if (!head_exp && (!out_v_ff || rsp.ready)) state_in = S_IDLE;
         S_OUT:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // control and reply path
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ttask_ff <= 5'd16;
         count_ff <= '0;
         out_v_ff <= 1'b0;
         nexp_ff  <= '0;
         for (int k = 0; k < NS; k++)
            flag_ff[k] <= (k == 0) ? stt_pkg::FL_RUN : stt_pkg::FL_FREE;
      end else begin
         state_ff <= state_in;
         out_v_ff <= out_v_in;
         if (csr.valid) ttask_ff <= csr.data;
         if (req_acc) begin
            out_ff <= reply_in;
            if (rq.func == stt_pkg::FN_TICK) begin
               count_ff <= count_ff + 32'd1;
               nexp_ff  <= '0;
            end
            if (rq.func == stt_pkg::FN_ALLOC && free_ok)
               flag_ff[free_idx] <= stt_pkg::FL_ALLOC;
            if ((rq.func == stt_pkg::FN_FREE || rq.func == stt_pkg::FN_SET) &&
                valid_idx && flag_ff[ins_idx] != stt_pkg::FL_RUN)
               flag_ff[ins_idx] <= (rq.func == stt_pkg::FN_SET) ?
                                   stt_pkg::FL_RUN : stt_pkg::FL_FREE;
         end else if (shift_en) begin
            // emit head expiry
            out_ff <= {stt_pkg::ST_OK, 4'(c_idx[0]),
                       emit_sw ? 8'd0 : byte_mem[c_idx[0]],
                       emit_sw ? 2'd0 : queue_mem[c_idx[0]],
                       emit_sw, 1'b1, emit_last};
            nexp_ff  <= nexp_ff + 4'd1;
            flag_ff[c_idx[0]] <= stt_pkg::FL_ALLOC;
         end
      end
   end

   // entry payload store
   always_ff @(posedge clock) begin
      if (req_acc && rq.func == stt_pkg::FN_INIT && valid_idx) begin
         byte_mem[ins_idx]  <= rq.data_byte;
         queue_mem[ins_idx] <= rq.queue_id;
      end
   end

   `STT_ASSERT(a_one_hot, clock, reset, $onehot(state_ff), "state not one-hot")
   `STT_ASSERT(a_no_acc_busy, clock, reset, (state_ff != S_IDLE) |-> !req.ready,
               "request taken while busy")
   `STT_ASSERT(a_sentinel, clock, reset, flag_ff[0] == stt_pkg::FL_RUN,
               "sentinel lost running state")
endmodule
`default_nettype wire

>>> src/stt_cell.sv
// One timer slot of the sorted list; slots form a chain ordered by deadline.
// Depends on stt_pkg.
`default_nettype none
module stt_cell #(
   parameter int IW = 4
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          shift_en,     // move contents toward the head
   input  wire logic [IW-1:0] up_idx,
   input  wire logic [31:0]   up_dl,
   input  wire logic          up_ins,       // slot lies past the insertion point
   input  wire logic          ins_en,       // insert transaction this cycle
   input  wire logic          ins_here,     // this slot takes the new entry
   input  wire logic [IW-1:0] ins_idx,
   input  wire logic [31:0]   ins_dl,
   input  wire logic [IW-1:0] dn_idx,       // head-side neighbor contents
   input  wire logic [31:0]   dn_dl,
   output logic [IW-1:0]      idx_q,
   output logic [31:0]        dl_q
);
   logic [IW-1:0] idx_ff, idx_in;
   logic [31:0]   dl_ff, dl_in;

   // hold, shift head-ward on expiry, or move tail-ward past an insertion
   always_comb begin
      idx_in = idx_ff;
      dl_in  = dl_ff;
      if (shift_en) begin
         idx_in = up_idx;
         dl_in  = up_dl;
      end else if (ins_en) begin
         if (ins_here) begin
            idx_in = ins_idx;
            dl_in  = ins_dl;
         end else if (up_ins) begin
            idx_in = dn_idx;
            dl_in  = dn_dl;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         dl_ff  <= stt_pkg::DL_MAX;
      end else begin
         idx_ff <= idx_in;
         dl_ff  <= dl_in;
      end
   end

   assign idx_q = idx_ff;
   assign dl_q  = dl_ff;
endmodule
`default_nettype wire
